### sv/fpba_pkg.sv
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = 5;
    localparam int SLOT_W     = 4;
    localparam int SIZE_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } t_policy;

    typedef enum logic {
        MODE_LOAD    = 1'b0,
        MODE_REQUEST = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
    } t_in_word;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] chosen_block;
        logic [SIZE_W-1:0] remaining;
    } t_out_word;

endpackage

### sv/fit_policy_block_allocator.sv
// Top level of the fit-policy block allocator: sequencer, shared compare unit, config.
// Load word: written to the table when taken, no result, busy stays low.
// Request word: one table read per active block through a registered read port,
//   then the result in the done state, after the last compare;
//   busy is high in the scan and result states, so the next word is not
//   taken before the previous result has been shown.
// The result is shown for one cycle with o_done; the receiver cannot stall.
// Reset (i_rst_n low, synchronous): idle, first fit, 16 blocks, all sizes zero.
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_cmd,
    output logic                  o_done,
    output t_out_word             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state               r_state, n_state;
    logic [1:0]           r_policy;
    logic [CNT_W-1:0]     r_block_count;

    // scan registers
    logic [CNT_W-1:0]     r_active;     // blocks to search, saturated
    logic [CNT_W-1:0]     r_idx;        // next address to read
    logic                 r_pend;       // read data in flight for r_cmp_idx
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [SIZE_BITS-1:0] r_size;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;

    logic                 accept;
    logic                 load_we;
    logic                 slot_ok;
    logic                 issue;
    logic                 take;
    logic                 fits;
    logic                 better;
    logic [SIZE_BITS-1:0] rd_val;
    logic [SIZE_BITS-1:0] left;
    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [SIZE_BITS-1:0] tbl_wdata;
    logic [CNT_W-1:0]     active_sat;

    assign accept  = start && !busy;
    assign slot_ok = ({1'b0, i_cmd.slot} < (SLOT_W+1)'(NUM_BLOCKS));
    assign load_we = accept && (i_cmd.mode == MODE_LOAD) && slot_ok;
    assign issue   = (r_state == ST_SCAN) && (r_idx < r_active);

    assign active_sat = (r_block_count > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                             : r_block_count;

    // shared compare unit: one table word per cycle against request and best so far
    assign fits = (rd_val >= r_size);
    always_comb begin
        case (r_policy)
            POL_BEST:  better = (rd_val < r_best);
            POL_WORST: better = (rd_val > r_best);
            default:   better = 1'b0;   // first fit keeps the first hit
        endcase
    end
    assign take = r_pend && fits && (!r_found || better);

    assign left = r_best - r_size;

    // table write: loads in idle, charge of the chosen block in the result cycle
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = i_cmd.slot[IDX_W-1:0];
        tbl_wdata = i_cmd.size[SIZE_BITS-1:0];
        if (r_state == ST_DONE) begin
            tbl_we    = r_found;
            tbl_waddr = r_pick;
            tbl_wdata = left;
        end else if (load_we) begin
            tbl_we = 1'b1;
        end
    end

    fpba_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_val)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_cmd.mode == MODE_REQUEST)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // last compare lands at this edge, result shows next cycle
                if (!issue) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy   = 1'b0;
        o_done = 1'b0;
        o_res  = '0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_SCAN: busy = 1'b1;
            ST_DONE: begin
                busy               = 1'b1;
                o_done             = 1'b1;
                o_res.granted      = r_found;
                o_res.chosen_block = r_found ? SLOT_W'(r_pick) : '0;
                o_res.remaining    = r_found ? SIZE_W'(left) : '0;
            end
            default: busy = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_policy      <= POL_FIRST;
            r_block_count <= BLOCK_COUNT_RST;
            r_idx         <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIT_POLICY:  r_policy      <= i_cfg_data[1:0];
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_pend <= issue;
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_size   <= i_cmd.size[SIZE_BITS-1:0];
            r_active <= active_sat;
        end
        r_cmp_idx <= r_idx[IDX_W-1:0];
        if (take) begin
            r_best <= rd_val;
            r_pick <= r_cmp_idx;
        end
    end

endmodule

### sv/fpba_table.sv
// Free-size table: one write port, one registered read port, cleared by valid bits.
module fpba_table
    import fpba_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  logic [SIZE_BITS-1:0] i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output logic [SIZE_BITS-1:0] o_rdata
);

    logic [SIZE_BITS-1:0]  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_raddr];
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_rd_valid ? r_rd_data : '0;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the fit-policy block allocator.
`timescale 1ns / 100ps

module tb;
    import fpba_pkg::*;

    // 2-bit policy code with no named policy; the block treats it as first fit
    localparam logic [1:0] POL_SPARE   = 2'd3;
    localparam int         RAND_WORDS  = 950;
    localparam int         TAIL_CYCLES = 25;       // > one full 16-block scan
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Allocation tracker: own copy of the free-size table and both
    // registers; predicts each grant at the moment a word is accepted.
    // ------------------------------------------------------------------
    class alloc_tracker;
        logic [SIZE_W-1:0] free_sz [NUM_BLOCKS];
        logic [1:0]        policy;
        logic [CNT_W-1:0]  active_cnt;
        t_out_word         grant_q [$];
        int                errors, loads, requests, grants, refusals, reg_writes;
        int                per_policy [4];

        function void reset();
            policy     = POL_FIRST;
            active_cnt = BLOCK_COUNT_RST;
            foreach (free_sz[k]) free_sz[k] = '0;
        endfunction

        function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            reg_writes++;
            if (idx == CFG_FIT_POLICY)
                policy = d[1:0];
            else if (idx == CFG_BLOCK_COUNT)
                active_cnt = d[CNT_W-1:0];
        endfunction

        function void take_word(t_in_word w);
            int        scan_n;
            int        pick;
            bit        found;
            t_out_word g;
            if (w.mode == MODE_LOAD) begin
                loads++;
                free_sz[w.slot] = w.size;
                return;
            end
            requests++;
            per_policy[policy]++;
            scan_n = (active_cnt > NUM_BLOCKS) ? NUM_BLOCKS : active_cnt;
            found  = 0;
            pick   = 0;
            for (int k = 0; k < scan_n; k++) begin
                if (free_sz[k] < w.size)
                    continue;
                if (!found) begin
                    found = 1;
                    pick  = k;
                    // first fit (and the spare code) stops at the first hit
                    if (policy != POL_BEST && policy != POL_WORST)
                        break;
                end else if (policy == POL_BEST && free_sz[k] < free_sz[pick]) begin
                    pick = k;
                end else if (policy == POL_WORST && free_sz[k] > free_sz[pick]) begin
                    pick = k;
                end
            end
            g = '0;
            if (found) begin
                free_sz[pick]  = free_sz[pick] - w.size;
                g.granted      = 1'b1;
                g.chosen_block = pick[SLOT_W-1:0];
                g.remaining    = free_sz[pick];
                grants++;
            end else begin
                refusals++;
            end
            grant_q.push_back(g);
        endfunction

        function void check_grant(t_out_word got);
            t_out_word want;
            if (grant_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] result with none pending: g=%0d blk=%0d rem=%0d",
                             $time, got.granted, got.chosen_block, got.remaining);
                return;
            end
            want = grant_q.pop_front();
            if (got.granted !== want.granted || got.chosen_block !== want.chosen_block ||
                got.remaining !== want.remaining) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] mismatch: exp g=%0d blk=%0d rem=%0d, got g=%0d blk=%0d rem=%0d",
                             $time, want.granted, want.chosen_block, want.remaining,
                             got.granted, got.chosen_block, got.remaining);
            end
        endfunction

        function int pending();
            return grant_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_cmd;
    logic                  o_done;
    t_out_word             o_res;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fit_policy_block_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    alloc_tracker sb;
    int           cycles;
    int           burst_left;
    int           phases;

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: o_done marks a one-cycle result word; no back-pressure exists,
    // so every strobed word is checked at the edge that ends its cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_grant(o_res);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All drive changes happen at falling edges; every task
    // is entered and left at a falling edge.
    // ------------------------------------------------------------------
    function automatic t_in_word mk_word(t_mode m, logic [SLOT_W-1:0] s,
                                         logic [SIZE_W-1:0] z);
        t_in_word w;
        w.mode = m;
        w.slot = s;
        w.size = z;
        return w;
    endfunction

    // Load sizes: full range, coarse multiples (to force ties), small values, all ones or mid range.
    function automatic logic [SIZE_W-1:0] load_size();
        case ($urandom_range(0, 3))
            0: return SIZE_W'($urandom_range(0, 65535));
            1: return SIZE_W'($urandom_range(1, 8) * 1024);
            2: return SIZE_W'($urandom_range(0, 1023));
            default: return ($urandom_range(0, 1)) ? '1 : SIZE_W'($urandom_range(2048, 40000));
        endcase
    endfunction

    // Request sizes mostly well under typical loads so grants are common;
    // a slice of full-range and zero-size requests keeps refusals and the
    // zero-size corner in the mix.
    function automatic logic [SIZE_W-1:0] req_size();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SIZE_W'($urandom_range(0, 2047));
            4, 5:       return SIZE_W'($urandom_range(1, 4) * 1024);
            6, 7:       return SIZE_W'($urandom_range(0, 65535));
            8:          return SIZE_W'($urandom_range(2048, 20000));
            default:    return '0;
        endcase
    endfunction

    // Sender pacing: bursts of random length, random gaps between them.
    // Called at the falling edge right after a word was taken.
    task automatic pace();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Present one word and hold it until the block takes it (start && !busy).
    task automatic put_word(t_in_word w);
        start <= 1'b1;
        i_cmd <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.take_word(w);
        @(negedge i_clk);
        pace();
    endtask

    // Let every pending result arrive, then give a load that might still be in
    // flight a full scan's worth of cycles before touching the registers.
    task automatic settle();
        if (start)
            start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.note_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Policy write with the unused upper data bits randomized.
    task automatic set_policy(logic [1:0] p);
        write_reg(CFG_FIT_POLICY, {CFG_DATA_W'($urandom_range(0, 7)) << 2} | p);
    endtask

    task automatic set_count(logic [CNT_W-1:0] c);
        write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(c));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int         target;
        int         len;
        int         r;
        logic [1:0] pol;
        logic [CNT_W-1:0] cnt;

        start      = 1'b0;
        i_cmd      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        cycles     = 0;
        burst_left = 1;
        phases     = 0;
        sb = new;
        sb.reset();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed: reset settings (first fit, 16 blocks, empty table) ---
        // zero-size request on an all-zero table still grants block 0
        put_word(mk_word(MODE_REQUEST, 4'd7, '0));
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd1));          // nothing fits
        put_word(mk_word(MODE_LOAD, 4'd0, '1));
        put_word(mk_word(MODE_LOAD, 4'd15, '1));
        put_word(mk_word(MODE_LOAD, 4'd5, 16'd300));
        put_word(mk_word(MODE_LOAD, 4'd9, 16'd100));
        put_word(mk_word(MODE_LOAD, 4'd3, 16'd300));
        put_word(mk_word(MODE_REQUEST, 4'd15, '1));            // drains block 0 exactly
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd200));        // lowest fit: block 3
        settle();

        // best fit with a tie (blocks 3 and 9 both at 100): lowest index wins
        set_policy(POL_BEST);
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd50));
        settle();
        set_policy(POL_WORST);
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd1));
        settle();
        set_policy(POL_SPARE);                                  // acts as first fit
        put_word(mk_word(MODE_REQUEST, 4'd0, '0));
        settle();
        set_count(5'd0);                                        // nothing searched
        put_word(mk_word(MODE_REQUEST, 4'd0, '0));
        settle();
        set_count(5'd31);                                       // saturates to 16
        set_policy(POL_BEST);
        put_word(mk_word(MODE_REQUEST, 4'd0, '1));
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd60000));
        settle();
        set_count(5'd1);
        set_policy(POL_FIRST);
        put_word(mk_word(MODE_REQUEST, 4'd0, 16'd1));
        settle();

        // --- random phases: new settings, optional refill, then a mixed run ---
        target = sb.loads + sb.requests + RAND_WORDS;
        while (sb.loads + sb.requests < target) begin
            phases++;
            r = $urandom_range(0, 9);
            pol = (r < 3) ? POL_FIRST : (r < 6) ? POL_BEST : (r < 9) ? POL_WORST : POL_SPARE;
            r = $urandom_range(0, 19);
            if (r == 0)
                cnt = 5'd0;
            else if (r == 1)
                cnt = 5'd1;
            else if (r < 4)
                cnt = ($urandom_range(0, 1)) ? 5'd31 : CNT_W'($urandom_range(17, 30));
            else if (r < 10)
                cnt = CNT_W'($urandom_range(2, 15));
            else
                cnt = 5'd16;
            set_policy(pol);
            set_count(cnt);

            // refill some blocks so the requests have something to carve up
            if ($urandom_range(0, 2) != 0) begin
                for (int s = 0; s < NUM_BLOCKS; s++)
                    if ($urandom_range(0, 3) != 0)
                        put_word(mk_word(MODE_LOAD, SLOT_W'(s), load_size()));
            end

            len = $urandom_range(20, 60);
            repeat (len) begin
                if ($urandom_range(0, 9) < 4)
                    put_word(mk_word(MODE_LOAD, SLOT_W'($urandom_range(0, 15)), load_size()));
                else
                    put_word(mk_word(MODE_REQUEST, SLOT_W'($urandom_range(0, 15)),
                                     req_size()));
            end
            // the sender stops here until every grant of the phase is back
            settle();
        end

        settle();
        $display("Run covered %0d loads and %0d requests (%0d granted, %0d refused), %0d register writes, %0d random phases.",
                 sb.loads, sb.requests, sb.grants, sb.refusals, sb.reg_writes, phases);
        $display("Requests per policy: first %0d, best %0d, worst %0d, spare code %0d; %0d errors.",
                 sb.per_policy[0], sb.per_policy[1], sb.per_policy[2], sb.per_policy[3],
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/fpba_pkg.sv
sv/fpba_table.sv
sv/fit_policy_block_allocator.sv
tb/sv/tb.sv
